### design/trs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package trs_pkg;

    localparam int CW         = 32;
    localparam int QF         = 14;
    localparam int QW         = 16;
    localparam int SCALE_FRAC = 16;
    localparam int TW         = CW + 2;
    localparam int STAGES     = 8;

    localparam int PROD1_W = 2 * CW;
    localparam int RND1_W  = PROD1_W - SCALE_FRAC;
    localparam int PROD2_W = QW + CW;
    localparam int CROSS_W = PROD2_W + 1;
    localparam int RND2_W  = CROSS_W - (QF - 1);
    localparam int PROD3_W = QW + TW;
    localparam int ACC_W   = PROD3_W + 2;
    localparam int RND3_W  = ACC_W - QF;
    localparam int SUM_W   = RND3_W + 1;

    localparam logic signed [PROD1_W-1:0] HALF1 = PROD1_W'(1) << (SCALE_FRAC - 1);
    localparam logic signed [CROSS_W-1:0] HALF2 = CROSS_W'(1) << (QF - 2);
    localparam logic signed [ACC_W-1:0]   HALF3 = ACC_W'(1) << (QF - 1);

    localparam int AX_B [3] = '{1, 2, 0};
    localparam int AX_C [3] = '{2, 0, 1};

    typedef logic [2:0] t_cfg_index;

    localparam t_cfg_index CFG_SCALE_X  = 3'd0;
    localparam t_cfg_index CFG_SCALE_Y  = 3'd1;
    localparam t_cfg_index CFG_SCALE_Z  = 3'd2;
    localparam t_cfg_index CFG_ROT_QUAT = 3'd3;
    localparam t_cfg_index CFG_OFFSET_X = 3'd4;
    localparam t_cfg_index CFG_OFFSET_Y = 3'd5;
    localparam t_cfg_index CFG_OFFSET_Z = 3'd6;

    localparam logic [31:0] SCALE_RESET = 32'h0001_0000;
    localparam logic [63:0] QUAT_RESET  = 64'h4000_0000_0000_0000;

    localparam logic CMD_POINT = 1'b0;
    localparam logic CMD_DIR   = 1'b1;

    typedef struct packed {
        logic               command;
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               saturated;
    } t_out_item;

endpackage

`default_nettype wire

### design/trs_point_transform.sv
// trs_point_transform: scale, quaternion rotate and translate one 3-D vector
// per transaction, all signed fixed point (Q16.16 coordinates, Q2.14 quat).
//
// Channels:
//   in  : i_in_valid / o_in_ready, payload i_in_data (command, in_x/y/z).
//         command 0 adds the offset (point), 1 skips it (direction).
//   out : o_out_valid / i_out_ready, payload o_out_data (out_x/y/z, saturated).
//   cfg : i_cfg_valid / o_cfg_ready (always high), i_cfg_index, i_cfg_data.
//         Index 0..2 scale, 3 quaternion (64 bits), 4..6 offset; others dropped.
//         Write only while no transaction is in flight.
// Each transaction passes through the 8-stage multiply/round/clamp pipeline;
// throughput is one vector per cycle while the receiver does not stall.
// When the receiver stalls, results stay in their stages and empty stages
// still fill, so input is held off only once all 8 stages are occupied.
// Reset (synchronous, active low) empties the pipeline and loads identity
// scale, identity rotation and zero offset.
`timescale 1ns / 1ps
`default_nettype none

module trs_point_transform (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire trs_pkg::t_in_item   i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output trs_pkg::t_out_item       o_out_data,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire trs_pkg::t_cfg_index i_cfg_index,
    input  wire logic [63:0]         i_cfg_data
);

    logic signed [31:0] r_scale  [3];
    logic signed [31:0] r_offset [3];
    logic        [63:0] r_quat;

    logic signed [trs_pkg::QW-1:0] q [3];
    logic signed [trs_pkg::QW-1:0] qw;

    logic [trs_pkg::STAGES-1:0] r_vld;
    logic [trs_pkg::STAGES:0]   en;

    logic signed [31:0] v [3];

    logic signed [trs_pkg::PROD1_W-1:0] r1_p [3];
    logic                               r1_cmd;

    logic signed [trs_pkg::CW-1:0]      r2_s [3];
    logic                               r2_cmd, r2_sat;

    logic signed [trs_pkg::PROD2_W-1:0] r3_pa [3];
    logic signed [trs_pkg::PROD2_W-1:0] r3_pb [3];
    logic signed [trs_pkg::CW-1:0]      r3_s [3];
    logic                               r3_cmd, r3_sat;

    logic signed [trs_pkg::TW-1:0]      r4_t [3];
    logic signed [trs_pkg::CW-1:0]      r4_s [3];
    logic                               r4_cmd, r4_sat;

    logic signed [trs_pkg::PROD3_W-1:0] r5_w  [3];
    logic signed [trs_pkg::PROD3_W-1:0] r5_da [3];
    logic signed [trs_pkg::PROD3_W-1:0] r5_db [3];
    logic signed [trs_pkg::CW-1:0]      r5_s  [3];
    logic                               r5_cmd, r5_sat;

    logic signed [trs_pkg::ACC_W-1:0]   r6_acc [3];
    logic                               r6_cmd, r6_sat;

    logic signed [trs_pkg::RND3_W-1:0]  r7_r [3];
    logic                               r7_cmd, r7_sat;

    trs_pkg::t_out_item r_out;

    logic signed [trs_pkg::PROD1_W-1:0] n2_sum [3];
    logic signed [trs_pkg::RND1_W-1:0]  n2_rnd [3];
    logic signed [trs_pkg::CW-1:0]      n2_s   [3];
    logic [2:0]                         n2_ovf;

    logic signed [trs_pkg::CROSS_W-1:0] n4_sum [3];
    logic signed [trs_pkg::RND2_W-1:0]  n4_rnd [3];
    logic signed [trs_pkg::TW-1:0]      n4_t   [3];
    logic [2:0]                         n4_ovf;

    logic signed [trs_pkg::ACC_W-1:0]   n6_acc [3];
    logic signed [trs_pkg::ACC_W-1:0]   n7_sum [3];

    logic signed [trs_pkg::SUM_W-1:0]   n8_off [3];
    logic signed [trs_pkg::SUM_W-1:0]   n8_sum [3];
    logic signed [trs_pkg::CW-1:0]      n8_r   [3];
    logic [2:0]                         n8_ovf;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale[0]  <= trs_pkg::SCALE_RESET;
            r_scale[1]  <= trs_pkg::SCALE_RESET;
            r_scale[2]  <= trs_pkg::SCALE_RESET;
            r_quat      <= trs_pkg::QUAT_RESET;
            r_offset[0] <= '0;
            r_offset[1] <= '0;
            r_offset[2] <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                trs_pkg::CFG_SCALE_X:  r_scale[0]  <= i_cfg_data[31:0];
                trs_pkg::CFG_SCALE_Y:  r_scale[1]  <= i_cfg_data[31:0];
                trs_pkg::CFG_SCALE_Z:  r_scale[2]  <= i_cfg_data[31:0];
                trs_pkg::CFG_ROT_QUAT: r_quat      <= i_cfg_data;
                trs_pkg::CFG_OFFSET_X: r_offset[0] <= i_cfg_data[31:0];
                trs_pkg::CFG_OFFSET_Y: r_offset[1] <= i_cfg_data[31:0];
                trs_pkg::CFG_OFFSET_Z: r_offset[2] <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign q[0] = $signed(r_quat[15:0]);
    assign q[1] = $signed(r_quat[31:16]);
    assign q[2] = $signed(r_quat[47:32]);
    assign qw   = $signed(r_quat[63:48]);

    assign v[0] = i_in_data.in_x;
    assign v[1] = i_in_data.in_y;
    assign v[2] = i_in_data.in_z;

    // a stage loads when it is empty or its content moves on
    always_comb begin
        en[trs_pkg::STAGES] = i_out_ready;
        for (int k = trs_pkg::STAGES - 1; k >= 0; k--) begin
            en[k] = ~r_vld[k] | en[k+1];
        end
    end

    assign o_in_ready  = en[0];
    assign o_out_valid = r_vld[trs_pkg::STAGES-1];
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < trs_pkg::STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            // scale: round, clamp to coordinate width
            n2_sum[i] = r1_p[i] + trs_pkg::HALF1;
            n2_rnd[i] = n2_sum[i][trs_pkg::PROD1_W-1:trs_pkg::SCALE_FRAC];
            n2_ovf[i] = ~(&n2_rnd[i][trs_pkg::RND1_W-1:trs_pkg::CW-1])
                        & (|n2_rnd[i][trs_pkg::RND1_W-1:trs_pkg::CW-1]);
            n2_s[i]   = n2_ovf[i]
                        ? {n2_rnd[i][trs_pkg::RND1_W-1],
                           {(trs_pkg::CW-1){~n2_rnd[i][trs_pkg::RND1_W-1]}}}
                        : n2_rnd[i][trs_pkg::CW-1:0];

            // t = 2*cross(q, s), back to Q16.16, clamp
            n4_sum[i] = trs_pkg::CROSS_W'(r3_pa[i]) - trs_pkg::CROSS_W'(r3_pb[i])
                        + trs_pkg::HALF2;
            n4_rnd[i] = n4_sum[i][trs_pkg::CROSS_W-1:trs_pkg::QF-1];
            n4_ovf[i] = ~(&n4_rnd[i][trs_pkg::RND2_W-1:trs_pkg::TW-1])
                        & (|n4_rnd[i][trs_pkg::RND2_W-1:trs_pkg::TW-1]);
            n4_t[i]   = n4_ovf[i]
                        ? {n4_rnd[i][trs_pkg::RND2_W-1],
                           {(trs_pkg::TW-1){~n4_rnd[i][trs_pkg::RND2_W-1]}}}
                        : n4_rnd[i][trs_pkg::TW-1:0];

            n6_acc[i] = (trs_pkg::ACC_W'(r5_s[i]) <<< trs_pkg::QF)
                        + trs_pkg::ACC_W'(r5_w[i])
                        + trs_pkg::ACC_W'(r5_da[i])
                        - trs_pkg::ACC_W'(r5_db[i]);

            n7_sum[i] = r6_acc[i] + trs_pkg::HALF3;

            n8_off[i] = (r7_cmd == trs_pkg::CMD_POINT)
                        ? trs_pkg::SUM_W'(r_offset[i]) : trs_pkg::SUM_W'(0);
            n8_sum[i] = trs_pkg::SUM_W'(r7_r[i]) + n8_off[i];
            n8_ovf[i] = ~(&n8_sum[i][trs_pkg::SUM_W-1:trs_pkg::CW-1])
                        & (|n8_sum[i][trs_pkg::SUM_W-1:trs_pkg::CW-1]);
            n8_r[i]   = n8_ovf[i]
                        ? {n8_sum[i][trs_pkg::SUM_W-1],
                           {(trs_pkg::CW-1){~n8_sum[i][trs_pkg::SUM_W-1]}}}
                        : n8_sum[i][trs_pkg::CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int i = 0; i < 3; i++) begin
                r1_p[i] <= trs_pkg::PROD1_W'(v[i]) * trs_pkg::PROD1_W'(r_scale[i]);
            end
            r1_cmd <= i_in_data.command;
        end
        if (en[1]) begin
            for (int i = 0; i < 3; i++) begin
                r2_s[i] <= n2_s[i];
            end
            r2_cmd <= r1_cmd;
            r2_sat <= |n2_ovf;
        end
        if (en[2]) begin
            for (int i = 0; i < 3; i++) begin
                r3_pa[i] <= trs_pkg::PROD2_W'(q[trs_pkg::AX_B[i]])
                            * trs_pkg::PROD2_W'(r2_s[trs_pkg::AX_C[i]]);
                r3_pb[i] <= trs_pkg::PROD2_W'(q[trs_pkg::AX_C[i]])
                            * trs_pkg::PROD2_W'(r2_s[trs_pkg::AX_B[i]]);
                r3_s[i]  <= r2_s[i];
            end
            r3_cmd <= r2_cmd;
            r3_sat <= r2_sat;
        end
        if (en[3]) begin
            for (int i = 0; i < 3; i++) begin
                r4_t[i] <= n4_t[i];
                r4_s[i] <= r3_s[i];
            end
            r4_cmd <= r3_cmd;
            r4_sat <= r3_sat | (|n4_ovf);
        end
        if (en[4]) begin
            for (int i = 0; i < 3; i++) begin
                r5_w[i]  <= trs_pkg::PROD3_W'(qw) * trs_pkg::PROD3_W'(r4_t[i]);
                r5_da[i] <= trs_pkg::PROD3_W'(q[trs_pkg::AX_B[i]])
                            * trs_pkg::PROD3_W'(r4_t[trs_pkg::AX_C[i]]);
                r5_db[i] <= trs_pkg::PROD3_W'(q[trs_pkg::AX_C[i]])
                            * trs_pkg::PROD3_W'(r4_t[trs_pkg::AX_B[i]]);
                r5_s[i]  <= r4_s[i];
            end
            r5_cmd <= r4_cmd;
            r5_sat <= r4_sat;
        end
        if (en[5]) begin
            for (int i = 0; i < 3; i++) begin
                r6_acc[i] <= n6_acc[i];
            end
            r6_cmd <= r5_cmd;
            r6_sat <= r5_sat;
        end
        if (en[6]) begin
            for (int i = 0; i < 3; i++) begin
                r7_r[i] <= n7_sum[i][trs_pkg::ACC_W-1:trs_pkg::QF];
            end
            r7_cmd <= r6_cmd;
            r7_sat <= r6_sat;
        end
        if (en[7]) begin
            r_out.out_x     <= n8_r[0];
            r_out.out_y     <= n8_r[1];
            r_out.out_z     <= n8_r[2];
            r_out.saturated <= r7_sat | (|n8_ovf);
        end
    end

`ifndef NO_ASSERTIONS
    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[trs_pkg::STAGES-1] |-> o_in_ready)
        else $error("input held off with an empty output stage");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_vld[0])
        else $error("accepted transaction missing from first stage");

    a_cfg_scale_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready && i_cfg_index == trs_pkg::CFG_SCALE_X
        |=> r_scale[0] == $past(i_cfg_data[31:0]))
        else $error("scale_x write lost");
`endif

endmodule

`default_nettype wire
